// ===== rtl/lmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lmbs_pkg: shared types and constants of the LED matrix bit-plane splitter
// Holds the job record passed from the front end to the back end, the
// register map and the fixed field widths of the stream channels.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    // Fixed field widths
    localparam int ADDR_W   = 17;
    localparam int DOT_W    = 6;
    localparam int PLANE_W  = 2;
    localparam int COORD_W  = 8;
    localparam int COLOR_W  = 16;
    localparam int SCAN_W   = 3;
    localparam int PCFG_W   = 4;

    // Panel geometry
    localparam int PANEL_SHIFT   = 5;   // 32 pixels per panel side
    localparam int HALF_PANEL_SH = 9;   // 512 dot pairs per panel
    localparam int ROW_MOD_W     = 7;   // widest scan row index
    localparam logic [PLANE_W-1:0] LAST_PLANE = 2'd2;

    // Job queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Register map, index is paddr[3:2]
    typedef enum logic [1:0] {
        REG_PANELS_WIDE = 2'd0,
        REG_PANELS_HIGH = 2'd1,
        REG_SCAN_LOG2   = 2'd2,
        REG_COLOR_ORDER = 2'd3
    } t_reg_idx;

    // Three most significant bits of each color channel of both pixels
    typedef struct packed {
        logic [2:0] r0;
        logic [2:0] g0;
        logic [2:0] b0;
        logic [2:0] r1;
        logic [2:0] g1;
        logic [2:0] b1;
    } t_bits;

    // One classified pixel pair ready for address expansion
    typedef struct packed {
        logic [ADDR_W-1:0]  base;  // scan row times panel count plus matrix
        logic [COORD_W-1:0] xm;    // column within its scan segment
        t_bits              bits;
    } t_job;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/lmbs_front.sv =====
// ----------------------------------------------------------------------------
// lmbs_front: input stage of the bit-plane splitter
// Accepts pixel pairs, drops those outside the frame or in a lower half band,
// and turns the rest into jobs holding the coarse scan offset and color bits.
// ----------------------------------------------------------------------------
module lmbs_front #(
    parameter int MAX_PANELS_WIDE = 8,
    parameter int MAX_PANELS_HIGH = 8,
    parameter int PWPH_W          = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic [lmbs_pkg::PCFG_W-1:0]    i_panels_wide,
    input  logic [lmbs_pkg::PCFG_W-1:0]    i_panels_high,
    input  logic [lmbs_pkg::SCAN_W-1:0]    i_scan_log2,
    input  logic                           i_color_order,
    // Pixel pair input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lmbs_pkg::COORD_W-1:0]   i_column,
    input  logic [lmbs_pkg::COORD_W-1:0]   i_row,
    input  logic [lmbs_pkg::COLOR_W-1:0]   i_upper_color,
    input  logic [lmbs_pkg::COLOR_W-1:0]   i_lower_color,
    // Job output towards the queue
    output logic                           o_push,
    output lmbs_pkg::t_job                 o_job,
    input  lmbs_pkg::t_q_status            i_q_status,
    // Panel count product for the back end
    output logic [PWPH_W-1:0]              o_pwph
);

    localparam int PW_W   = $clog2(MAX_PANELS_WIDE + 1);
    localparam int PH_W   = $clog2(MAX_PANELS_HIGH + 1);
    localparam int BASE_W = lmbs_pkg::ROW_MOD_W + PWPH_W + 1;

    logic [PW_W-1:0]                    pw;
    logic [PH_W-1:0]                    ph;
    logic [PH_W-1:0]                    ph_rem;
    logic [2:0]                         xb;
    logic [2:0]                         yb;
    logic [lmbs_pkg::ROW_MOD_W-1:0]     row_mask;
    logic [lmbs_pkg::ROW_MOD_W-1:0]     ym;
    logic [lmbs_pkg::COORD_W-1:0]       seg_mask;
    logic [PWPH_W-1:0]                  pwph;
    logic [PWPH_W-1:0]                  matrix;
    logic [BASE_W-1:0]                  base_full;
    logic                               keep;
    logic                               accept;
    lmbs_pkg::t_job                     job;

    logic                               r_vld;
    logic                               n_vld;
    lmbs_pkg::t_job                     r_job;
    logic [PWPH_W-1:0]                  r_pwph;

    // Saturate the panel counts to the supported range.
    always_comb begin
        if (i_panels_wide == '0) begin
            pw = PW_W'(1);
        end else if (32'(i_panels_wide) > MAX_PANELS_WIDE) begin
            pw = PW_W'(MAX_PANELS_WIDE);
        end else begin
            pw = PW_W'(i_panels_wide);
        end
        if (i_panels_high == '0) begin
            ph = PH_W'(1);
        end else if (32'(i_panels_high) > MAX_PANELS_HIGH) begin
            ph = PH_W'(MAX_PANELS_HIGH);
        end else begin
            ph = PH_W'(i_panels_high);
        end
    end

    // Classify the pair and work out the coarse part of its scan index.
    always_comb begin
        pwph      = PWPH_W'(pw) * PWPH_W'(ph);
        xb        = i_column[lmbs_pkg::COORD_W-1:lmbs_pkg::PANEL_SHIFT];
        yb        = i_row[lmbs_pkg::COORD_W-1:lmbs_pkg::PANEL_SHIFT];
        keep      = (32'(xb) < 32'(pw)) && (32'(yb) < 32'(ph))
                    && !i_row[lmbs_pkg::PANEL_SHIFT-1];
        row_mask  = lmbs_pkg::ROW_MOD_W'((8'd1 << i_scan_log2) - 8'd1);
        ym        = i_row[lmbs_pkg::ROW_MOD_W-1:0] & row_mask;
        seg_mask  = lmbs_pkg::COORD_W'((10'd512 >> i_scan_log2) - 10'd1);
        ph_rem    = ph - PH_W'(1) - PH_W'(yb);
        matrix    = PWPH_W'(pw) * PWPH_W'(ph_rem) + PWPH_W'(xb);
        base_full = BASE_W'(ym) * BASE_W'(pwph) + BASE_W'(matrix);

        job.base  = lmbs_pkg::ADDR_W'(base_full);
        job.xm    = i_column & seg_mask;
        job.bits.r0 = i_upper_color[15:13];
        job.bits.r1 = i_lower_color[15:13];
        if (i_color_order) begin
            job.bits.b0 = i_upper_color[10:8];
            job.bits.g0 = i_upper_color[4:2];
            job.bits.b1 = i_lower_color[10:8];
            job.bits.g1 = i_lower_color[4:2];
        end else begin
            job.bits.g0 = i_upper_color[10:8];
            job.bits.b0 = i_upper_color[4:2];
            job.bits.g1 = i_lower_color[10:8];
            job.bits.b1 = i_lower_color[4:2];
        end
    end

    // The stage takes a new pair whenever it is empty or its job can move on to the queue.
    assign o_push  = r_vld && !i_q_status.full;
    assign o_ready = !r_vld || !i_q_status.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = keep;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Payload registers; the panel product follows the static configuration.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= job;
        end
        r_pwph <= pwph;
    end

    assign o_job  = r_job;
    assign o_pwph = r_pwph;

endmodule

// ===== rtl/lmbs_queue.sv =====
// ----------------------------------------------------------------------------
// lmbs_queue: job queue between front end and back end
// A two-entry first-in first-out buffer so that either side can stall alone.
// ----------------------------------------------------------------------------
module lmbs_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lmbs_pkg::t_job       i_job,
    input  logic                 i_pop,
    output lmbs_pkg::t_job       o_job,
    output lmbs_pkg::t_q_status  o_status
);

    lmbs_pkg::t_job                  r_mem [lmbs_pkg::Q_DEPTH];
    logic [lmbs_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [lmbs_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [lmbs_pkg::Q_CNT_W-1:0]    r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_status.full  = (r_count == lmbs_pkg::Q_CNT_W'(lmbs_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    // Pointer and fill count bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/lmbs_back.sv =====
// ----------------------------------------------------------------------------
// lmbs_back: plane expansion stage of the bit-plane splitter
// Takes one job at a time and emits its three plane results, one per cycle while
// the receiver is ready, through an output register that a stalled receiver can hold.
// ----------------------------------------------------------------------------
module lmbs_back #(
    parameter int PWPH_W = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lmbs_pkg::SCAN_W-1:0]     i_scan_log2,
    input  logic [PWPH_W-1:0]               i_pwph,
    // Queue side
    input  lmbs_pkg::t_job                  i_job,
    input  lmbs_pkg::t_q_status             i_q_status,
    output logic                            o_pop,
    // Result stream
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lmbs_pkg::ADDR_W-1:0]     o_address,
    output logic [lmbs_pkg::DOT_W-1:0]      o_dot_pair,
    output logic [lmbs_pkg::PLANE_W-1:0]    o_plane,
    output logic                            o_last
);

    localparam int WIDE_W = PWPH_W + lmbs_pkg::HALF_PANEL_SH;

    logic [lmbs_pkg::ADDR_W-1:0]   half;
    logic [lmbs_pkg::ADDR_W-1:0]   idx;
    logic [3:0]                    base_sh;
    logic                          slot_free;
    logic                          emit;
    logic                          done_plane;
    logic [lmbs_pkg::DOT_W-1:0]    dot;

    logic                          r_busy;
    logic [lmbs_pkg::PLANE_W-1:0]  r_k;
    logic [lmbs_pkg::ADDR_W-1:0]   r_addr;
    lmbs_pkg::t_bits               r_bits;

    logic                          r_out_vld;
    logic [lmbs_pkg::ADDR_W-1:0]   r_out_addr;
    logic [lmbs_pkg::DOT_W-1:0]    r_out_dot;
    logic [lmbs_pkg::PLANE_W-1:0]  r_out_plane;
    logic                          r_out_last;

    // Plane stride is the dot pair count of the frame, half its pixel count.
    always_comb begin
        half    = lmbs_pkg::ADDR_W'(WIDE_W'(i_pwph) << lmbs_pkg::HALF_PANEL_SH);
        base_sh = 4'(lmbs_pkg::HALF_PANEL_SH) - 4'(i_scan_log2);
        idx     = lmbs_pkg::ADDR_W'(i_job.base << base_sh)
                  + lmbs_pkg::ADDR_W'(i_job.xm);
    end

    // Advance when the output register is empty or being drained.
    assign slot_free  = !r_out_vld || i_ready;
    assign emit       = r_busy && slot_free;
    assign done_plane = r_k == lmbs_pkg::LAST_PLANE;
    assign o_pop      = !i_q_status.empty && (!r_busy || (emit && done_plane));

    // Bit k of each channel of both pixels.
    assign dot = {r_bits.r0[r_k], r_bits.g0[r_k], r_bits.b0[r_k],
                  r_bits.r1[r_k], r_bits.g1[r_k], r_bits.b1[r_k]};

    // Job sequencing and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (emit) begin
                r_k <= r_k + 1'b1;
                if (done_plane) begin
                    r_busy <= 1'b0;
                end
            end
            if (slot_free) begin
                r_out_vld <= emit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_addr <= idx;
            r_bits <= i_job.bits;
        end else if (emit) begin
            r_addr <= r_addr + half;
        end
        if (emit) begin
            r_out_addr  <= r_addr;
            r_out_dot   <= dot;
            r_out_plane <= r_k;
            r_out_last  <= done_plane;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_address  = r_out_addr;
    assign o_dot_pair = r_out_dot;
    assign o_plane    = r_out_plane;
    assign o_last     = r_out_last;

    // A taken plane that is not the last is followed at once by the next one.
    a_plane_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_ready && !r_out_last) |=>
        (r_out_vld && r_out_plane == $past(r_out_plane) + 1'b1))
        else $error("next plane did not follow");

    // The plane counter never leaves the three planes.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k != 2'd3))
        else $error("plane counter out of range");

    // A busy stage with room in the output register always produces a result.
    a_busy_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && slot_free) |=> r_out_vld)
        else $error("busy stage produced no result");

    // Taking a new job restarts the plane count and makes the stage busy.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_k == '0 && r_busy))
        else $error("job load did not restart the plane count");

endmodule

// ===== rtl/led_matrix_bitplane_splitter_core.sv =====
// ----------------------------------------------------------------------------
// led_matrix_bitplane_splitter_core: HUB75 bit-plane splitter for chained
// 32x32 panels
// Splits RGB565 pixel pairs into three dot-pair bytes with frame addresses.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream takes one pixel pair per transaction: column, row of the
// upper pixel, and the colors of that pixel and of the pixel 16 rows below.
// Each pair whose row lies in an upper half band inside the frame yields three
// master stream transactions, planes 0, 1, 2 in order, tlast on plane 2. Other
// pairs are accepted and dropped.
// A pair passes the input stage register, the job queue, the plane expansion
// registers and the output register. One pair is accepted per cycle until the
// two-entry job queue fills; the expansion stage emits one result per cycle
// while the receiver is ready, so the single result channel sets the sustained
// rate. When the receiver stalls, the output register holds its result and
// the queue absorbs up to two more jobs plus one in the input stage before
// s_axis_tready drops. Reset empties every stage and loads the registers with
// 4 panels wide, 1 panel high, 1/16 scan and RGB order.
// The APB port may only be written while the block is idle.
// ----------------------------------------------------------------------------
module led_matrix_bitplane_splitter_core #(
    parameter int MAX_PANELS_WIDE = 8,
    parameter int MAX_PANELS_HIGH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Pixel pair stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // column, row, upper_color, lower_color
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // address, dot_pair, zero pad
    output logic [1:0]  o_m_axis_tuser,   // plane
    output logic        o_m_axis_tlast
);

    localparam int PWPH_W = $clog2(MAX_PANELS_WIDE + 1) + $clog2(MAX_PANELS_HIGH + 1);

    logic [lmbs_pkg::PCFG_W-1:0]   r_panels_wide;
    logic [lmbs_pkg::PCFG_W-1:0]   r_panels_high;
    logic [lmbs_pkg::SCAN_W-1:0]   r_scan_log2;
    logic                          r_color_order;

    lmbs_pkg::t_reg_idx            reg_idx;
    logic                          cfg_wr;
    logic                          push;
    logic                          pop;
    lmbs_pkg::t_job                front_job;
    lmbs_pkg::t_job                queue_job;
    lmbs_pkg::t_q_status           q_status;
    logic [PWPH_W-1:0]             pwph;
    logic [lmbs_pkg::ADDR_W-1:0]   out_address;
    logic [lmbs_pkg::DOT_W-1:0]    out_dot;

    // Register access decode.
    assign pready  = 1'b1;
    assign reg_idx = lmbs_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panels_wide <= 4'd4;
            r_panels_high <= 4'd1;
            r_scan_log2   <= 3'd4;
            r_color_order <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                lmbs_pkg::REG_PANELS_WIDE: r_panels_wide <= pwdata[3:0];
                lmbs_pkg::REG_PANELS_HIGH: r_panels_high <= pwdata[3:0];
                lmbs_pkg::REG_SCAN_LOG2:   r_scan_log2   <= pwdata[2:0];
                lmbs_pkg::REG_COLOR_ORDER: r_color_order <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        case (reg_idx)
            lmbs_pkg::REG_PANELS_WIDE: prdata = 32'(r_panels_wide);
            lmbs_pkg::REG_PANELS_HIGH: prdata = 32'(r_panels_high);
            lmbs_pkg::REG_SCAN_LOG2:   prdata = 32'(r_scan_log2);
            lmbs_pkg::REG_COLOR_ORDER: prdata = 32'(r_color_order);
            default:                   prdata = '0;
        endcase
    end

    // Input classification.
    lmbs_front #(
        .MAX_PANELS_WIDE (MAX_PANELS_WIDE),
        .MAX_PANELS_HIGH (MAX_PANELS_HIGH),
        .PWPH_W          (PWPH_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_panels_wide (r_panels_wide),
        .i_panels_high (r_panels_high),
        .i_scan_log2   (r_scan_log2),
        .i_color_order (r_color_order),
        .i_valid       (i_s_axis_tvalid),
        .o_ready       (o_s_axis_tready),
        .i_column      (i_s_axis_tdata[7:0]),
        .i_row         (i_s_axis_tdata[15:8]),
        .i_upper_color (i_s_axis_tdata[31:16]),
        .i_lower_color (i_s_axis_tdata[47:32]),
        .o_push        (push),
        .o_job         (front_job),
        .i_q_status    (q_status),
        .o_pwph        (pwph)
    );

    // Job buffering.
    lmbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (queue_job),
        .o_status (q_status)
    );

    // Plane expansion.
    lmbs_back #(
        .PWPH_W (PWPH_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_scan_log2 (r_scan_log2),
        .i_pwph      (pwph),
        .i_job       (queue_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_address   (out_address),
        .o_dot_pair  (out_dot),
        .o_plane     (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_dot, out_address};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LED matrix bit-plane splitter
// Streams pixel pairs through the splitter under a series of panel geometries,
// scan settings and color orders. Each kept pair is predicted into its three plane
// bytes when the core accepts it. Every plane byte that comes out is compared
// field by field with the oldest prediction. Random gaps on the pair stream
// and random stalls on the result stream vary the timing.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          MAX_PW      = 8;
    localparam int          MAX_PH      = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 20;
    localparam int          N_GEO       = 11;

    // Register settings used by the random phases, extremes and saturation included
    localparam logic [3:0] GEO_PW    [N_GEO] = '{1, 8, 0, 15, 2, 8, 3, 4, 8, 5, 7};
    localparam logic [3:0] GEO_PH    [N_GEO] = '{1, 8, 15, 0, 3, 8, 2, 1, 8, 7, 1};
    localparam logic [2:0] GEO_SCAN  [N_GEO] = '{1, 4, 0, 7, 5, 6, 2, 4, 3, 1, 5};
    localparam logic       GEO_ORDER [N_GEO] = '{0, 1, 1, 0, 1, 0, 1, 0, 1, 0, 1};

    typedef struct packed {
        logic [lmbs_pkg::COORD_W-1:0] column;
        logic [lmbs_pkg::COORD_W-1:0] row;
        logic [lmbs_pkg::COLOR_W-1:0] upper_color;
        logic [lmbs_pkg::COLOR_W-1:0] lower_color;
    } t_pixel_pair;

    typedef struct packed {
        logic [lmbs_pkg::ADDR_W-1:0]  address;
        logic [lmbs_pkg::DOT_W-1:0]   dot_pair;
        logic [lmbs_pkg::PLANE_W-1:0] plane;
        logic                         last;
    } t_plane_byte;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata  = '0;   // column, row, upper_color, lower_color
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;         // address, dot_pair, zero pad
    logic [1:0]  o_m_axis_tuser;         // plane
    logic        o_m_axis_tlast;

    // Bench copy of the configuration registers
    logic [3:0] cfg_panels_wide = 4'd4;
    logic [3:0] cfg_panels_high = 4'd1;
    logic [2:0] cfg_scan_log2   = 3'd4;
    logic       cfg_color_order = 1'b0;

    t_pixel_pair pixel_pairs[$];
    t_plane_byte plane_bytes_due[$];
    t_pixel_pair pair_on_bus;

    int unsigned cycle_cnt      = 0;
    int unsigned src_wait       = 0;
    int unsigned sink_wait      = 0;
    int unsigned pairs_accepted = 0;
    int unsigned bytes_checked  = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 1;

    led_matrix_bitplane_splitter_core #(
        .MAX_PANELS_WIDE(MAX_PW),
        .MAX_PANELS_HIGH(MAX_PH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Panel counts outside the legal range saturate to the nearest bound.
    function automatic int unsigned clamp_panels(input logic [3:0] v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Quiet windows with no idling alternate with windows of random waits.
    function automatic int unsigned draw_wait(input logic quiet);
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    // Work out the three plane bytes that one pixel pair must produce.
    function automatic void expand_pair_to_planes(input t_pixel_pair p);
        int unsigned pw, ph, wd, ht, scan_rows, seg, half, matrix, idx;
        logic [2:0]  r0, g0, b0, r1, g1, b1;
        t_plane_byte pb;
        pw = clamp_panels(cfg_panels_wide, MAX_PW);
        ph = clamp_panels(cfg_panels_high, MAX_PH);
        wd = pw * 32;
        ht = ph * 32;
        // Pairs outside the frame or starting in a lower half band are dropped.
        if (p.column >= wd || p.row >= ht || (p.row % 32) >= 16) return;
        scan_rows = 1 << cfg_scan_log2;
        seg       = 512 / scan_rows;
        half      = wd * ht / 2;
        matrix    = pw * ph - (p.row / 32 + 1) * pw + p.column / 32;
        idx       = (p.row % scan_rows) * (half / scan_rows) + matrix * seg
                    + p.column % seg;
        r0 = p.upper_color[15:13];
        r1 = p.lower_color[15:13];
        g0 = cfg_color_order ? p.upper_color[4:2] : p.upper_color[10:8];
        b0 = cfg_color_order ? p.upper_color[10:8] : p.upper_color[4:2];
        g1 = cfg_color_order ? p.lower_color[4:2] : p.lower_color[10:8];
        b1 = cfg_color_order ? p.lower_color[10:8] : p.lower_color[4:2];
        for (int k = 0; k < 3; k++) begin
            pb.address  = lmbs_pkg::ADDR_W'(k * half + idx);
            pb.dot_pair = {r0[k], g0[k], b0[k], r1[k], g1[k], b1[k]};
            pb.plane    = lmbs_pkg::PLANE_W'(k);
            pb.last     = (pb.plane == lmbs_pkg::LAST_PLANE);
            plane_bytes_due.push_back(pb);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Pixel pair driver: presents queued pairs, predicting each on acceptance.
    always @(posedge i_clk) begin : drive_pairs
        t_pixel_pair p;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            src_wait        <= 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expand_pair_to_planes(pair_on_bus);
                pairs_accepted++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (src_wait != 0) begin
                    src_wait        <= src_wait - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pixel_pairs.size() != 0) begin
                    p = pixel_pairs.pop_front();
                    pair_on_bus     <= p;
                    i_s_axis_tdata  <= {p.lower_color, p.upper_color, p.row, p.column};
                    i_s_axis_tvalid <= 1'b1;
                    src_wait        <= draw_wait(cycle_cnt[9:8] == 2'b11);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each plane byte transaction and paces tready.
    always @(posedge i_clk) begin : check_planes
        t_plane_byte want;
        int unsigned stall;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_wait       <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (plane_bytes_due.size() == 0) begin
                $error("unexpected plane byte: address %0d, plane %0d",
                       o_m_axis_tdata[lmbs_pkg::ADDR_W-1:0], o_m_axis_tuser);
                mismatches++;
            end else begin
                want = plane_bytes_due.pop_front();
                check_field("address", want.address,
                            o_m_axis_tdata[lmbs_pkg::ADDR_W-1:0]);
                check_field("dot_pair", want.dot_pair,
                            o_m_axis_tdata[lmbs_pkg::ADDR_W+lmbs_pkg::DOT_W-1:
                                           lmbs_pkg::ADDR_W]);
                check_field("plane", want.plane, o_m_axis_tuser);
                check_field("last", want.last, o_m_axis_tlast);
                bytes_checked++;
            end
            stall = draw_wait(cycle_cnt[10:9] == 2'b01);
            if (stall == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                sink_wait       <= stall - 1;
            end
        end else if (!i_m_axis_tready) begin
            if (sink_wait == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                sink_wait <= sink_wait - 1;
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // One APB write: setup cycle, then access cycle.
    task automatic write_reg(input lmbs_pkg::t_reg_idx idx, input logic [3:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            lmbs_pkg::REG_PANELS_WIDE: cfg_panels_wide = value;
            lmbs_pkg::REG_PANELS_HIGH: cfg_panels_high = value;
            lmbs_pkg::REG_SCAN_LOG2:   cfg_scan_log2   = value[2:0];
            lmbs_pkg::REG_COLOR_ORDER: cfg_color_order = value[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [3:0] pw, input logic [3:0] ph,
                                input logic [2:0] scan, input logic order);
        write_reg(lmbs_pkg::REG_PANELS_WIDE, pw);
        write_reg(lmbs_pkg::REG_PANELS_HIGH, ph);
        write_reg(lmbs_pkg::REG_SCAN_LOG2, {1'b0, scan});
        write_reg(lmbs_pkg::REG_COLOR_ORDER, {3'b000, order});
        settings_used++;
    endtask

    // Wait until every pair is consumed and every plane byte has come back,
    // then give the pipeline time to flush pairs that were dropped.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_pairs.size() != 0 || i_s_axis_tvalid || src_wait != 0
               || plane_bytes_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic push_pair(input logic [7:0] x, input logic [7:0] y,
                             input logic [15:0] c0, input logic [15:0] c1);
        pixel_pairs.push_back('{x, y, c0, c1});
    endtask

    // Mostly pairs that land in an upper half band of the frame, some noise.
    task automatic push_random_pair();
        int unsigned pw, ph;
        pw = clamp_panels(cfg_panels_wide, MAX_PW);
        ph = clamp_panels(cfg_panels_high, MAX_PH);
        if ($urandom_range(0, 4) == 0) begin
            push_pair(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
        end else begin
            push_pair(8'($urandom_range(0, pw * 32 - 1)),
                      8'(32 * $urandom_range(0, ph - 1) + $urandom_range(0, 15)),
                      16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: 128x32 frame, 1/16 scan, RGB order.
        push_pair(8'd0, 8'd0, 16'h0000, 16'h0000);
        push_pair(8'd127, 8'd15, 16'hFFFF, 16'hFFFF);
        push_pair(8'd128, 8'd0, 16'hFFFF, 16'hFFFF);   // right of the frame
        push_pair(8'd0, 8'd32, 16'hFFFF, 16'hFFFF);    // below the frame
        push_pair(8'd5, 8'd16, 16'hFFFF, 16'hFFFF);    // lower half band
        push_pair(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        push_pair(8'd31, 8'd7, 16'hE000, 16'h001C);
        push_pair(8'd32, 8'd8, 16'h0700, 16'hE000);
        push_pair(8'd64, 8'd3, 16'h001C, 16'h0700);
        push_pair(8'd96, 8'd12, 16'hAAAA, 16'h5555);
        push_pair(8'd100, 8'd1, 16'h5555, 16'hAAAA);
        push_pair(8'd17, 8'd9, 16'h18E3, 16'h18E3);    // only bits that are not sampled
        wait_idle();

        // Largest frame, coarsest scan, green and blue swapped.
        set_geometry(4'd8, 4'd8, 3'd7, 1'b1);
        push_pair(8'd255, 8'd239, 16'h0700, 16'h001C);
        push_pair(8'd0, 8'd0, 16'hFFFF, 16'h0000);
        push_pair(8'd200, 8'd100, 16'h001C, 16'h0700);
        push_pair(8'd128, 8'd240, 16'hFFFF, 16'hFFFF); // lower half band
        push_pair(8'd77, 8'd143, 16'hE71C, 16'h18E3);
        wait_idle();

        // Zero panel counts saturate to one panel; single scan row.
        set_geometry(4'd0, 4'd0, 3'd0, 1'b0);
        push_pair(8'd31, 8'd15, 16'hFFFF, 16'h5555);
        push_pair(8'd0, 8'd0, 16'hAAAA, 16'hFFFF);
        push_pair(8'd32, 8'd0, 16'hFFFF, 16'hFFFF);    // right of the frame
        push_pair(8'd0, 8'd31, 16'hFFFF, 16'hFFFF);    // lower half band
        wait_idle();

        for (int g = 0; g < N_GEO; g++) begin
            set_geometry(GEO_PW[g], GEO_PH[g], GEO_SCAN[g], GEO_ORDER[g]);
            repeat (12) push_random_pair();
            wait_idle();
        end

        $display("summary: %0d pixel pairs accepted under %0d register settings,",
                 pairs_accepted, settings_used);
        $display("summary: %0d plane bytes checked, %0d mismatches",
                 bytes_checked, mismatches);
        if (mismatches == 0 && plane_bytes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== led_matrix_bitplane_splitter_core.f =====
rtl/lmbs_pkg.sv
rtl/lmbs_front.sv
rtl/lmbs_queue.sv
rtl/lmbs_back.sv
rtl/led_matrix_bitplane_splitter_core.sv
verif/tb_top.sv
